>>> rtl/obm_pkg.sv
`default_nettype none

package obm_pkg;

	// Default width of the phase countdown timer
	localparam int unsigned TIMER_BITS_DEF = 10;

	// Configuration port widths
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	// Configuration register widths
	localparam int unsigned RST_W   = 10;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned SHORT_W = 8;

	// Reset values of the timing registers
	localparam logic [RST_W-1:0]   RESET_LOW_DEF    = 10'd480;
	localparam logic [RST_W-1:0]   RESET_WAIT_DEF   = 10'd480;
	localparam logic [SLOT_W-1:0]  SLOT_LOW_DEF     = 4'd2;
	localparam logic [SHORT_W-1:0] WRITE_HOLD_DEF   = 8'd60;
	localparam logic [SHORT_W-1:0] READ_SAMPLE_DEF  = 8'd15;
	localparam logic [SHORT_W-1:0] READ_RECOVER_DEF = 8'd45;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_LOW    = 3'd0,
		REG_RESET_WAIT   = 3'd1,
		REG_SLOT_LOW     = 3'd2,
		REG_WRITE_HOLD   = 3'd3,
		REG_READ_SAMPLE  = 3'd4,
		REG_READ_RECOVER = 3'd5
	} reg_idx_t;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Bus phases of the back end
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_SLOT_LOW = 3'd3,
		PH_W_HOLD   = 3'd4,
		PH_W_REC    = 3'd5,
		PH_R_SAMP   = 3'd6,
		PH_R_REC    = 3'd7
	} phase_t;

	// One classified beat travelling from front to back
	typedef struct packed {
		logic       is_cmd;
		op_t        op;
		logic [7:0] data;
		logic       level;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/obm_front.sv
`default_nettype none

module obm_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       op,
	input  wire logic [7:0]       data_byte,
	input  wire logic             line_level,
	output logic                  item_valid,
	input  wire logic             item_ready,
	output obm_pkg::item_t        item
);

	obm_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;
	obm_pkg::item_t classified;

	// Classify the incoming beat
	always_comb begin
		classified.op     = obm_pkg::op_t'(op);
		classified.is_cmd = (obm_pkg::op_t'(op) != obm_pkg::OP_TICK);
		classified.data   = data_byte;
		classified.level  = line_level;
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_valid && item_ready;
	assign item       = entry_q[rd_ptr_q];

	// Store beats in the two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue fill count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |=> (count_q != 2'd2))
		else $error("queue went from empty to full in one cycle");

endmodule

`default_nettype wire

>>> rtl/obm_back.sv
`default_nettype none

module obm_back #(
	parameter int unsigned TIMER_BITS = obm_pkg::TIMER_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [obm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [obm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire obm_pkg::item_t                  item,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 drive_low,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [7:0]                           read_data
);

	localparam int unsigned LW = (TIMER_BITS > obm_pkg::RST_W) ? TIMER_BITS : obm_pkg::RST_W;
	localparam logic [TIMER_BITS-1:0] TOP = {TIMER_BITS{1'b1}};
	localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

	// Timing registers
	logic [obm_pkg::RST_W-1:0]   reset_low_q;
	logic [obm_pkg::RST_W-1:0]   reset_wait_q;
	logic [obm_pkg::SLOT_W-1:0]  slot_low_q;
	logic [obm_pkg::SHORT_W-1:0] write_hold_q;
	logic [obm_pkg::SHORT_W-1:0] read_sample_q;
	logic [obm_pkg::SHORT_W-1:0] read_recover_q;

	// Bus state
	obm_pkg::phase_t        phase_q, phase_d;
	logic [TIMER_BITS-1:0]  timer_q, timer_d;
	logic [2:0]             bit_cnt_q, bit_cnt_d;
	logic [7:0]             shift_q, shift_d;
	logic                   is_read_q, is_read_d;
	logic [7:0]             hold_q, hold_d;

	logic step;
	logic drive_d, busy_d, done_d, ends, cur_bit;

	// Output register
	logic       out_valid_q;
	logic       drive_q, busy_q, done_q;

	// Clamp a phase length to one tick at least and the timer range at most
	function automatic logic [TIMER_BITS-1:0] phase_len(input logic [obm_pkg::RST_W-1:0] v);
		logic [LW-1:0] ext;
		ext = LW'(v);
		if (ext == '0) begin
			phase_len = ONE;
		end else if (ext > LW'(TOP)) begin
			phase_len = TOP;
		end else begin
			phase_len = TIMER_BITS'(ext);
		end
	endfunction

	assign cfg_ready  = 1'b1;
	assign step       = item_valid && (!out_valid_q || out_ready);
	assign item_ready = step;

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q    <= obm_pkg::RESET_LOW_DEF;
			reset_wait_q   <= obm_pkg::RESET_WAIT_DEF;
			slot_low_q     <= obm_pkg::SLOT_LOW_DEF;
			write_hold_q   <= obm_pkg::WRITE_HOLD_DEF;
			read_sample_q  <= obm_pkg::READ_SAMPLE_DEF;
			read_recover_q <= obm_pkg::READ_RECOVER_DEF;
		end else if (cfg_valid && cfg_ready) begin
			case (obm_pkg::reg_idx_t'(cfg_index))
				obm_pkg::REG_RESET_LOW:    reset_low_q    <= cfg_data;
				obm_pkg::REG_RESET_WAIT:   reset_wait_q   <= cfg_data;
				obm_pkg::REG_SLOT_LOW:     slot_low_q     <= cfg_data[obm_pkg::SLOT_W-1:0];
				obm_pkg::REG_WRITE_HOLD:   write_hold_q   <= cfg_data[obm_pkg::SHORT_W-1:0];
				obm_pkg::REG_READ_SAMPLE:  read_sample_q  <= cfg_data[obm_pkg::SHORT_W-1:0];
				obm_pkg::REG_READ_RECOVER: read_recover_q <= cfg_data[obm_pkg::SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Next phase and bus outputs for one tick
	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		is_read_d = is_read_q;
		hold_d    = hold_q;
		drive_d   = 1'b0;
		busy_d    = 1'b0;
		done_d    = 1'b0;
		ends      = 1'b0;
		cur_bit   = 1'b0;

		// Start a command when idle
		if (phase_q == obm_pkg::PH_IDLE && item.is_cmd) begin
			bit_cnt_d = 3'd0;
			if (item.op == obm_pkg::OP_RESET) begin
				is_read_d = 1'b0;
				phase_d   = obm_pkg::PH_RST_LOW;
				timer_d   = phase_len(reset_low_q);
			end else begin
				is_read_d = (item.op == obm_pkg::OP_READ);
				shift_d   = (item.op == obm_pkg::OP_READ) ? 8'h00 : item.data;
				phase_d   = obm_pkg::PH_SLOT_LOW;
				timer_d   = phase_len(obm_pkg::RST_W'(slot_low_q));
			end
		end

		// Run the current phase
		if (phase_d != obm_pkg::PH_IDLE) begin
			cur_bit = shift_d[bit_cnt_d];
			busy_d  = 1'b1;
			if (phase_d == obm_pkg::PH_RST_LOW || phase_d == obm_pkg::PH_SLOT_LOW) begin
				drive_d = 1'b1;
			end else if (phase_d == obm_pkg::PH_W_HOLD) begin
				drive_d = !cur_bit;
			end

			if (timer_d > ONE) begin
				timer_d = timer_d - ONE;
			end else begin
				case (phase_d)
					obm_pkg::PH_RST_LOW: begin
						phase_d = obm_pkg::PH_RST_WAIT;
						timer_d = phase_len(reset_wait_q);
					end
					obm_pkg::PH_RST_WAIT: begin
						ends = 1'b1;
					end
					obm_pkg::PH_SLOT_LOW: begin
						if (is_read_d) begin
							phase_d = obm_pkg::PH_R_SAMP;
							timer_d = phase_len(obm_pkg::RST_W'(read_sample_q));
						end else begin
							phase_d = obm_pkg::PH_W_HOLD;
							timer_d = phase_len(obm_pkg::RST_W'(write_hold_q));
						end
					end
					obm_pkg::PH_W_HOLD: begin
						phase_d = obm_pkg::PH_W_REC;
						timer_d = ONE;
					end
					obm_pkg::PH_R_SAMP: begin
						shift_d[bit_cnt_d] = shift_d[bit_cnt_d] | item.level;
						phase_d = obm_pkg::PH_R_REC;
						timer_d = phase_len(obm_pkg::RST_W'(read_recover_q));
					end
					default: begin
						// end of a write or read slot
						if (bit_cnt_d == 3'd7) begin
							if (is_read_d) begin
								hold_d = shift_d;
							end
							ends = 1'b1;
						end else begin
							bit_cnt_d = bit_cnt_d + 3'd1;
							phase_d   = obm_pkg::PH_SLOT_LOW;
							timer_d   = phase_len(obm_pkg::RST_W'(slot_low_q));
						end
					end
				endcase
				if (ends) begin
					done_d    = 1'b1;
					phase_d   = obm_pkg::PH_IDLE;
					timer_d   = '0;
					bit_cnt_d = 3'd0;
				end
			end
		end
	end

	// Hold the bus state, advance on each taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= obm_pkg::PH_IDLE;
			timer_q   <= '0;
			bit_cnt_q <= 3'd0;
			shift_q   <= 8'h00;
			is_read_q <= 1'b0;
			hold_q    <= 8'h00;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			is_read_q <= is_read_d;
			hold_q    <= hold_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			drive_q <= drive_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = drive_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign read_data = hold_q;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == obm_pkg::PH_IDLE) |-> (timer_q == '0 && bit_cnt_q == 3'd0))
		else $error("idle phase with live timer or bit count");

	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != obm_pkg::PH_IDLE) |-> (timer_q != '0))
		else $error("active phase with empty timer");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (done_q || drive_q)) |-> busy_q)
		else $error("done or drive reported outside an operation");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_d) |=> (phase_q == obm_pkg::PH_IDLE))
		else $error("operation finished but phase not idle");

endmodule

`default_nettype wire

>>> rtl/onewire_bus_master_core.sv
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_ready     op, data_byte, line_level
// out       out_valid / out_ready   drive_low, busy_res, done_res, read_data
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input beat is one 1 us tick and yields one output beat; the sustained
// rate is one beat per cycle unless out_ready stalls, set by the single-step phase
// logic of the back end. Beats pass the two-entry queue, then the output register.
// The queue and the output register let either side stall without losing beats.
// Reset restores the timing registers to their defaults and the bus to idle.
// cfg_ready is always high.
module onewire_bus_master_core #(
	parameter int unsigned TIMER_BITS = obm_pkg::TIMER_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [obm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [obm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      op,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            line_level,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 drive_low,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [7:0]                           read_data
);

	logic           item_valid;
	logic           item_ready;
	obm_pkg::item_t item;

	// Accept and classify beats
	obm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.data_byte  (data_byte),
		.line_level (line_level),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// Run the bus phases
	obm_back #(
		.TIMER_BITS (TIMER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive_low  (drive_low),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data)
	);

endmodule

`default_nettype wire

>>> verif/obm_status_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the single-wire bus master, keeps its own copy of the
// timing registers and the bus sequencer, and compares every output beat against the
// oldest predicted bus status.
module obm_status_checker
	import obm_pkg::*;
#(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [1:0]            op,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  line_level,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic                  drive_low,
	input  wire logic                  busy_res,
	input  wire logic                  done_res,
	input  wire logic [7:0]            read_data,
	output int                         miss_total,
	output int                         due_left,
	output logic                       line_idle,
	output logic                       deep_in_op
);

	typedef struct packed {
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
	} line_status_t;

	line_status_t status_due [$];

	// Timing registers as the block should hold them
	logic [RST_W-1:0]   rst_low, rst_wait;
	logic [SLOT_W-1:0]  slot_low;
	logic [SHORT_W-1:0] w_hold, r_samp, r_rec;

	// Sequencer state
	phase_t              ph;
	logic [TIMER_BITS-1:0] tmr;
	logic [2:0]          bit_no;
	logic [7:0]          shreg;
	logic                rd_mode;
	logic [7:0]          rd_hold;

	int misses;
	int out_beats;

	assign miss_total = misses;

	// Clamp a phase length to at least one tick and at most the timer range
	function automatic logic [TIMER_BITS-1:0] clamp_len(input int unsigned v);
		int unsigned top;
		top = (1 << TIMER_BITS) - 1;
		if (v < 1) v = 1;
		if (v > top) v = top;
		return TIMER_BITS'(v);
	endfunction

	// Advance the bus sequencer by one 1 us beat and produce its status
	task automatic tick_master(input op_t cmd, input logic [7:0] byte_in, input logic lvl,
			output line_status_t st);
		logic bitv;
		logic ends;
		st = '0;
		ends = 1'b0;
		// Start an operation only from idle; commands while busy act as ticks
		if (ph == PH_IDLE && cmd != OP_TICK) begin
			bit_no = 3'd0;
			if (cmd == OP_RESET) begin
				rd_mode = 1'b0;
				ph = PH_RST_LOW;
				tmr = clamp_len(rst_low);
			end else begin
				rd_mode = (cmd == OP_READ);
				shreg = rd_mode ? 8'h00 : byte_in;
				ph = PH_SLOT_LOW;
				tmr = clamp_len(slot_low);
			end
		end
		if (ph != PH_IDLE) begin
			bitv = shreg[bit_no];
			st.busy = 1'b1;
			if (ph == PH_RST_LOW || ph == PH_SLOT_LOW) st.drive = 1'b1;
			else if (ph == PH_W_HOLD) st.drive = !bitv;
			if (tmr > 1) begin
				tmr = tmr - 1'b1;
			end else begin
				case (ph)
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						tmr = clamp_len(rst_wait);
					end
					PH_RST_WAIT: ends = 1'b1;
					PH_SLOT_LOW: begin
						if (rd_mode) begin
							ph = PH_R_SAMP;
							tmr = clamp_len(r_samp);
						end else begin
							ph = PH_W_HOLD;
							tmr = clamp_len(w_hold);
						end
					end
					PH_W_HOLD: begin
						ph = PH_W_REC;
						tmr = clamp_len(1);
					end
					PH_R_SAMP: begin
						// sample the line on the last released tick
						shreg[bit_no] = shreg[bit_no] | lvl;
						ph = PH_R_REC;
						tmr = clamp_len(r_rec);
					end
					default: begin
						// end of a slot: next bit or finish the byte
						if (bit_no == 3'd7) begin
							if (rd_mode) rd_hold = shreg;
							ends = 1'b1;
						end else begin
							bit_no = bit_no + 1'b1;
							ph = PH_SLOT_LOW;
							tmr = clamp_len(slot_low);
						end
					end
				endcase
				if (ends) begin
					st.done = 1'b1;
					ph = PH_IDLE;
					tmr = '0;
					bit_no = 3'd0;
				end
			end
		end
		st.rdata = rd_hold;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		line_status_t st;
		line_status_t want;
		if (!arst_n) begin
			rst_low = RESET_LOW_DEF;
			rst_wait = RESET_WAIT_DEF;
			slot_low = SLOT_LOW_DEF;
			w_hold = WRITE_HOLD_DEF;
			r_samp = READ_SAMPLE_DEF;
			r_rec = READ_RECOVER_DEF;
			ph = PH_IDLE;
			tmr = '0;
			bit_no = 3'd0;
			shreg = 8'h00;
			rd_mode = 1'b0;
			rd_hold = 8'h00;
			status_due.delete();
			misses = 0;
			out_beats = 0;
			due_left <= 0;
			line_idle <= 1'b1;
			deep_in_op <= 1'b0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RESET_LOW:    rst_low = cfg_data;
					REG_RESET_WAIT:   rst_wait = cfg_data;
					REG_SLOT_LOW:     slot_low = cfg_data[SLOT_W-1:0];
					REG_WRITE_HOLD:   w_hold = cfg_data[SHORT_W-1:0];
					REG_READ_SAMPLE:  r_samp = cfg_data[SHORT_W-1:0];
					REG_READ_RECOVER: r_rec = cfg_data[SHORT_W-1:0];
					default: ;
				endcase
			end
			// Predict the status for each input beat
			if (in_valid && in_ready) begin
				tick_master(op_t'(op), data_byte, line_level, st);
				status_due.push_back(st);
			end
			// Compare each output beat with the oldest prediction
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("output beat %0d with no status due: drive %b busy %b done %b data %02h",
							out_beats, drive_low, busy_res, done_res, read_data);
				end else begin
					want = status_due.pop_front();
					if (drive_low !== want.drive || busy_res !== want.busy ||
							done_res !== want.done || read_data !== want.rdata) begin
						misses++;
						if (misses <= 10)
							$display({"status mismatch at beat %0d: want drive %b busy %b done %b data %02h,",
								" got drive %b busy %b done %b data %02h"},
								out_beats, want.drive, want.busy, want.done, want.rdata,
								drive_low, busy_res, done_res, read_data);
					end
				end
				out_beats++;
			end
			due_left <= status_due.size();
			line_idle <= (ph == PH_IDLE);
			// Busy, and the next beat cannot be the one that finishes the operation
			deep_in_op <= (ph != PH_IDLE) && !(tmr <= 1 && (ph == PH_RST_WAIT ||
				((ph == PH_W_REC || ph == PH_R_REC) && bit_no == 3'd7)));
		end
	end

endmodule

>>> verif/onewire_bus_master_core_tb.sv
`timescale 1ns / 100ps

module onewire_bus_master_core_tb;
	import obm_pkg::*;

	localparam int unsigned TMR_W = TIMER_BITS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_BEATS = 145;

	// Line level choices while an operation runs
	localparam int LVL_RANDOM = 0;
	localparam int LVL_HIGH   = 1;
	localparam int LVL_LOW    = 2;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            op = OP_TICK;
	logic [7:0]            data_byte = 8'h00;
	logic                  line_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  drive_low;
	logic                  busy_res;
	logic                  done_res;
	logic [7:0]            read_data;

	int   miss_total;
	int   due_left;
	logic line_idle;
	logic deep_in_op;
	logic steady = 1'b0;
	int   quiet = 0;

	onewire_bus_master_core #(
		.TIMER_BITS(TMR_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.line_level(line_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive_low (drive_low),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_data (read_data)
	);

	obm_status_checker #(
		.TIMER_BITS(TMR_W)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.line_level(line_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive_low (drive_low),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_data (read_data),
		.miss_total(miss_total),
		.due_left  (due_left),
		.line_idle (line_idle),
		.deep_in_op(deep_in_op)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stall the result side at random, except in the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 24);
	end

	// Drop the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic pick_level(input int mode);
		case (mode)
			LVL_HIGH: return 1'b1;
			LVL_LOW:  return 1'b0;
			default:  return 1'($urandom);
		endcase
	endfunction

	// Offer one input beat after a random gap and hold it until accepted
	task automatic send_beat(input op_t cmd, input logic [7:0] byte_v, input logic lvl);
		while (!steady && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		data_byte <= byte_v;
		line_level <= lvl;
		do @(posedge clk); while (!in_ready);
	endtask

	// Issue a command and tick until the bus is idle again; optionally throw in
	// commands while the operation is surely still running
	task automatic run_op(input op_t cmd, input logic [7:0] byte_v, input int lvl_mode,
			input bit poke);
		send_beat(cmd, byte_v, pick_level(lvl_mode));
		do begin
			if (poke && deep_in_op && $urandom_range(15) == 0)
				send_beat(op_t'(2'($urandom_range(OP_READ, OP_RESET))), 8'($urandom),
					pick_level(lvl_mode));
			else
				send_beat(OP_TICK, 8'($urandom), pick_level(lvl_mode));
		end while (!line_idle);
	endtask

	// Finish any bus operation, then hold off until every status beat is back
	task automatic settle();
		do send_beat(OP_TICK, 8'($urandom), 1'($urandom)); while (!line_idle);
		in_valid <= 1'b0;
		do @(posedge clk); while (due_left != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_timing(input logic [CFG_DATA_W-1:0] rl, rw, sl, wh, rs, rr);
		logic [CFG_DATA_W-1:0] vals [6];
		vals[0] = rl;
		vals[1] = rw;
		vals[2] = sl;
		vals[3] = wh;
		vals[4] = rs;
		vals[5] = rr;
		for (int i = REG_RESET_LOW; i <= REG_READ_RECOVER; i++)
			cfg_write(CFG_IDX_W'(i), vals[i]);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		op_t cmd;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default timing: a write with commands thrown in while busy
		run_op(OP_WRITE, 8'hA5, LVL_RANDOM, 1'b1);
		settle();

		// Shortest legal timing
		set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		run_op(OP_RESET, 8'h00, LVL_RANDOM, 1'b1);
		run_op(OP_WRITE, 8'h5A, LVL_RANDOM, 1'b0);
		run_op(OP_READ, 8'h00, LVL_HIGH, 1'b0);
		settle();

		// Zero registers still give one tick per phase
		set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		run_op(OP_RESET, 8'h00, LVL_RANDOM, 1'b0);
		run_op(OP_WRITE, 8'hC3, LVL_RANDOM, 1'b1);
		run_op(OP_READ, 8'hFF, LVL_LOW, 1'b0);
		settle();

		// Unused indexes are dropped; narrow registers keep their low bits
		for (int i = REG_READ_RECOVER + 1; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		set_timing(10'h011, 10'h013, 10'h3F2, 10'h303, 10'h302, 10'h304);
		run_op(OP_RESET, 8'h00, LVL_RANDOM, 1'b0);
		run_op(OP_WRITE, 8'h81, LVL_RANDOM, 1'b0);
		run_op(OP_READ, 8'h00, LVL_RANDOM, 1'b0);
		settle();

		// Random traffic under short random timing; one round runs with no stalls
		for (int round = 0; round < 4; round++) begin
			set_timing(CFG_DATA_W'($urandom_range(12, round & 1 ? 0 : 1)),
				CFG_DATA_W'($urandom_range(12, round & 1 ? 0 : 1)),
				CFG_DATA_W'($urandom_range(4, round & 1 ? 0 : 1)),
				CFG_DATA_W'($urandom_range(6, round & 1 ? 0 : 1)),
				CFG_DATA_W'($urandom_range(6, round & 1 ? 0 : 1)),
				CFG_DATA_W'($urandom_range(6, round & 1 ? 0 : 1)));
			steady <= (round == 2);
			repeat (RAND_BEATS) begin
				if ($urandom_range(99) < 72)
					cmd = OP_TICK;
				else
					cmd = op_t'(2'($urandom_range(OP_READ, OP_RESET)));
				send_beat(cmd, 8'($urandom), 1'($urandom));
			end
			steady <= 1'b0;
			settle();
		end

		// Let the output register drain, then give the verdict
		repeat (8) @(posedge clk);
		if (miss_total == 0 && due_left == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
rtl/obm_pkg.sv
rtl/obm_front.sv
rtl/obm_back.sv
rtl/onewire_bus_master_core.sv
verif/obm_status_checker.sv
verif/onewire_bus_master_core_tb.sv
